FILE: hdl/websocket_frame_deframer_macros.svh
// assertion macros shared by the deframer checker
// every macro samples on i_clk; the checked scope must declare i_clk and i_rst_n
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// property checked only outside reset
`define WSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define WSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/wsd_pkg.sv
// shared types and constants of the websocket frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int FIFO_DEPTH_DEF  = 4;
    localparam int LEN_W           = 63;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_HDR   = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // opcodes that matter to the parser
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    // one classified result, raw byte and key byte still apart
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       raw;
        logic [7:0]       key;
        logic [3:0]       opcode;
        logic             fin;
        logic             masked;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_rec;

endpackage

`default_nettype wire

FILE: hdl/wsd_front.sv
// header parser: takes one stream byte per transfer and classifies it
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_front #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output wsd_pkg::t_rec o_rec
);
    import wsd_pkg::*;

    // stored length: low LENGTH_BITS bits, the top bit of a 64-bit length dropped
    localparam int LW = (LENGTH_BITS >= 64) ? 63 : LENGTH_BITS;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CLOSED  = 3'd6;

    logic [2:0]    r_phase,  n_phase;
    logic [3:0]    r_opcode, n_opcode;
    logic          r_fin,    n_fin;
    logic          r_masked, n_masked;
    logic [2:0]    r_cnt,    n_cnt;
    logic [LW-1:0] r_len,    n_len;
    logic [31:0]   r_key,    n_key;
    logic [LW-1:0] r_remain, n_remain;
    logic [1:0]    r_idx,    n_idx;

    logic          hdr_done;
    logic          empty;
    logic          pay_last;
    logic [7:0]    key_byte;

    always_comb begin
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign pay_last = (r_remain == LW'(1));

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_masked = r_masked;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_key    = r_key;
        n_remain = r_remain;
        n_idx    = r_idx;
        hdr_done = 1'b0;
        empty    = 1'b0;
        o_push   = 1'b0;
        o_rec    = '0;
        if (i_take) begin
            case (r_phase)
                PH_HDR0: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    n_masked = i_byte[7];
                    n_len    = '0;
                    n_key    = '0;
                    n_cnt    = '0;
                    if (i_byte[6:0] == 7'd126) begin
                        n_phase = PH_EXT16;
                    end else if (i_byte[6:0] == 7'd127) begin
                        n_phase = PH_EXT64;
                    end else begin
                        n_len = LW'(i_byte[6:0]);
                        if (i_byte[7]) begin
                            n_phase = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    // big-endian shift, upper bits fall off the top
                    n_len = {r_len[LW-9:0], i_byte};
                    n_cnt = r_cnt + 3'd1;
                    if ((r_phase == PH_EXT16 && n_cnt == 3'd2) ||
                        (r_phase == PH_EXT64 && n_cnt == 3'd0)) begin
                        n_cnt = '0;
                        if (r_masked) begin
                            n_phase = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = r_cnt + 3'd1;
                    if (n_cnt == 3'd4) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_idx    = r_idx + 2'd1;
                    n_remain = r_remain - LW'(1);
                    if (pay_last) begin
                        n_phase = PH_HDR0;
                    end
                    if (r_opcode inside {OP_TEXT, OP_BINARY}) begin
                        o_push       = 1'b1;
                        o_rec.kind   = KIND_DATA;
                        o_rec.raw    = i_byte;
                        o_rec.key    = r_masked ? key_byte : 8'd0;
                        o_rec.opcode = r_opcode;
                        o_rec.fin    = r_fin;
                        o_rec.masked = r_masked;
                        o_rec.len    = LEN_W'(r_len);
                        o_rec.last   = pay_last;
                    end
                end
                PH_CLOSED: begin
                    n_phase = PH_CLOSED;
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            if (hdr_done) begin
                empty        = (n_len == '0);
                n_cnt        = '0;
                n_remain     = n_len;
                n_idx        = '0;
                o_push       = 1'b1;
                o_rec.opcode = n_opcode;
                o_rec.fin    = n_fin;
                o_rec.masked = n_masked;
                o_rec.len    = LEN_W'(n_len);
                o_rec.last   = empty;
                if (n_opcode == OP_CLOSE) begin
                    o_rec.kind = KIND_CLOSE;
                    n_phase    = PH_CLOSED;
                end else begin
                    o_rec.kind = KIND_HDR;
                    n_phase    = empty ? PH_HDR0 : PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_cnt    <= '0;
            r_len    <= '0;
            r_key    <= '0;
            r_remain <= '0;
            r_idx    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_key    <= n_key;
            r_remain <= n_remain;
            r_idx    <= n_idx;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wsd_fifo.sv
// short result queue between parser and output stage
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_fifo #(
    parameter int DEPTH = wsd_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wsd_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output wsd_pkg::t_rec o_rec
);
    import wsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wsd_back.sv
// output stage: unmasks payload bytes and holds the result register
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  wsd_pkg::t_rec             i_rec,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic [3:0]                o_opcode,
    output logic                      o_fin,
    output logic                      o_masked,
    output logic [wsd_pkg::LEN_W-1:0] o_payload_length,
    output logic                      o_last
);
    import wsd_pkg::*;

    logic             r_valid, n_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_data;
    logic [3:0]       r_opcode;
    logic             r_fin;
    logic             r_masked;
    logic [LEN_W-1:0] r_len;
    logic             r_last;

    // refill when the register is empty or being drained this cycle
    assign o_pop = !i_empty && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_rec.kind;
            r_data   <= i_rec.raw ^ i_rec.key;
            r_opcode <= i_rec.opcode;
            r_fin    <= i_rec.fin;
            r_masked <= i_rec.masked;
            r_len    <= i_rec.len;
            r_last   <= i_rec.last;
        end
    end

    assign o_valid          = r_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_opcode         = r_opcode;
    assign o_fin            = r_fin;
    assign o_masked         = r_masked;
    assign o_payload_length = r_len;
    assign o_last           = r_last;

endmodule

`default_nettype wire

FILE: hdl/websocket_frame_deframer.sv
// websocket receive deframer: one stream byte in per transfer, a header, close or
// unmasked payload byte out. The block takes one byte every clock cycle; the input
// only stalls once the four-entry result queue is full, which happens only while the
// output side holds off. The parser classifies each byte in the cycle it is taken and
// writes its result into the queue; the output register is then loaded from the
// queue. Headers give a header result (last set when the payload is empty), text and
// binary payload bytes come out unmasked, other payloads are dropped, and a close
// header gives one close result after which all input is swallowed until reset.
// Lengths keep their low LENGTH_BITS bits, 63 at most.
// depends on wsd_pkg, wsd_front, wsd_fifo, wsd_back
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF,
    parameter int FIFO_DEPTH  = wsd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte stream in
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_rx_byte,
    // results out
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_data_byte,
    output logic [3:0]                o_opcode,
    output logic                      o_fin,
    output logic                      o_masked,
    output logic [wsd_pkg::LEN_W-1:0] o_payload_length,
    output logic                      o_last
);
    import wsd_pkg::*;

    logic take;
    logic push;
    logic full;
    logic pop;
    logic empty;
    t_rec front_rec;
    t_rec queue_rec;

    // a byte is taken whenever the queue has room for whatever it may produce
    assign o_in_ready = !full;
    assign take       = i_in_valid && o_in_ready;

    // parser: header fields, length, mask key, payload position
    wsd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_push  (push),
        .o_rec   (front_rec)
    );

    // decouples the parser from output back-pressure
    wsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rec   (queue_rec)
    );

    // unmask and present each result transfer
    wsd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_rec            (queue_rec),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_opcode         (o_opcode),
        .o_fin            (o_fin),
        .o_masked         (o_masked),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

FILE: hdl/wsd_checker.sv
// port-level checks of the deframer, bound onto the top level
// depends on wsd_pkg and websocket_frame_deframer_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [7:0]                i_rx_byte,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                o_kind,
    input logic [7:0]                o_data_byte,
    input logic [3:0]                o_opcode,
    input logic                      o_fin,
    input logic                      o_masked,
    input logic [wsd_pkg::LEN_W-1:0] o_payload_length,
    input logic                      o_last
);
    import wsd_pkg::*;

    `WSD_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `WSD_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind), "stalled result dropped")
    `WSD_ASSERT(a_kind_legal, o_out_valid |-> (o_kind == KIND_DATA || o_kind == KIND_HDR || o_kind == KIND_CLOSE), "bad kind")
    `WSD_ASSERT(a_hdr_no_data, o_out_valid && o_kind != KIND_DATA |-> o_data_byte == 8'd0, "data on header")
    `WSD_ASSERT(a_close_final, o_out_valid && i_out_ready && o_kind == KIND_CLOSE |=> !o_out_valid, "result after close")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);

`default_nettype wire

FILE: tb/sv/websocket_frame_deframer_checker.sv
// scoreboard for the websocket deframer: follows every byte transfer, predicts the
// header, close and payload results and compares them with the output transfers
// depends on wsd_pkg
`timescale 1ns / 1ps

module websocket_frame_deframer_checker #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [1:0]                i_kind,
    input  logic [7:0]                i_data_byte,
    input  logic [3:0]                i_opcode,
    input  logic                      i_fin,
    input  logic                      i_masked,
    input  logic [wsd_pkg::LEN_W-1:0] i_payload_length,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        ST_HEAD0, ST_HEAD1, ST_EXT16, ST_EXT64, ST_KEY, ST_PAYLOAD, ST_CLOSED
    } t_parse_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [3:0]       opcode;
        logic             fin;
        logic             masked;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_frame_result;

    // decoded length keeps LENGTH_BITS bits, never the reserved top bit
    localparam logic [63:0] LEN_KEEP =
        ((LENGTH_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << LENGTH_BITS) - 64'd1))
        & {1'b0, {63{1'b1}}};

    t_parse_state  st;
    logic [3:0]    cur_op;
    logic          cur_fin;
    logic          cur_mask;
    logic [2:0]    fld_cnt;
    logic [63:0]   frame_len;
    logic [31:0]   mask_key;
    logic [63:0]   pay_cnt;
    t_frame_result predicted_results[$];
    t_frame_result got;
    t_frame_result want;

    function automatic string fmt_result(input t_frame_result r);
        return $sformatf("kind=%0d data=%h op=%h fin=%b masked=%b len=%0d last=%b",
                         r.kind, r.data, r.opcode, r.fin, r.masked, r.len, r.last);
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                         input logic last);
        t_frame_result r;
        r.kind   = kind;
        r.data   = data;
        r.opcode = cur_op;
        r.fin    = cur_fin;
        r.masked = cur_mask;
        r.len    = frame_len[LEN_W-1:0];
        r.last   = last;
        predicted_results.push_back(r);
    endfunction

    function automatic void end_of_header();
        logic empty;
        frame_len = frame_len & LEN_KEEP;
        pay_cnt   = '0;
        fld_cnt   = '0;
        empty     = (frame_len == 64'd0);
        if (cur_op == OP_CLOSE) begin
            queue_result(KIND_CLOSE, 8'd0, empty);
            st = ST_CLOSED;
        end else begin
            queue_result(KIND_HDR, 8'd0, empty);
            st = empty ? ST_HEAD0 : ST_PAYLOAD;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int         idx;
        logic [7:0] kb;
        logic       last;
        case (st)
            ST_HEAD0: begin
                cur_fin = b[7];
                cur_op  = b[3:0];
                st      = ST_HEAD1;
            end
            ST_HEAD1: begin
                cur_mask  = b[7];
                frame_len = '0;
                mask_key  = '0;
                fld_cnt   = '0;
                if (b[6:0] == 7'd126) begin
                    st = ST_EXT16;
                end else if (b[6:0] == 7'd127) begin
                    st = ST_EXT64;
                end else begin
                    frame_len = {57'd0, b[6:0]};
                    if (cur_mask) st = ST_KEY;
                    else end_of_header();
                end
            end
            ST_EXT16, ST_EXT64: begin
                frame_len = {frame_len[55:0], b};
                fld_cnt   = fld_cnt + 3'd1;
                if ((st == ST_EXT16 && fld_cnt == 3'd2) ||
                    (st == ST_EXT64 && fld_cnt == 3'd0)) begin
                    fld_cnt = '0;
                    if (cur_mask) st = ST_KEY;
                    else end_of_header();
                end
            end
            ST_KEY: begin
                mask_key = {mask_key[23:0], b};
                fld_cnt  = fld_cnt + 3'd1;
                if (fld_cnt == 3'd4) end_of_header();
            end
            ST_PAYLOAD: begin
                // key byte 0 sits in the top byte of the key register
                idx     = int'(pay_cnt[1:0]);
                kb      = cur_mask ? mask_key[31 - 8 * idx -: 8] : 8'd0;
                pay_cnt = pay_cnt + 64'd1;
                last    = (pay_cnt >= frame_len);
                if (last) st = ST_HEAD0;
                if (cur_op == OP_TEXT || cur_op == OP_BINARY)
                    queue_result(KIND_DATA, b ^ kb, last);
            end
            ST_CLOSED: begin
            end
            default: st = ST_HEAD0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            st        = ST_HEAD0;
            cur_op    = '0;
            cur_fin   = 1'b0;
            cur_mask  = 1'b0;
            fld_cnt   = '0;
            frame_len = '0;
            mask_key  = '0;
            pay_cnt   = '0;
            predicted_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                got.kind   = i_kind;
                got.data   = i_data_byte;
                got.opcode = i_opcode;
                got.fin    = i_fin;
                got.masked = i_masked;
                got.len    = i_payload_length;
                got.last   = i_last;
                if (predicted_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) $display("unexpected result: %s", fmt_result(got));
                end else begin
                    want = predicted_results.pop_front();
                    if (got !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(got));
                        end
                    end
                end
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

FILE: tb/sv/websocket_frame_deframer_tb.sv
// top of the websocket deframer testbench: clock, reset, byte stream and output stall
// pattern; the checker beside the block predicts and compares
// depends on wsd_pkg, websocket_frame_deframer, websocket_frame_deframer_checker
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam int     CLK_PERIOD    = 4;
    localparam int     STREAM_TARGET = 650;
    localparam int     DRAIN_CYCLES  = 20;
    localparam longint CYCLE_LIMIT   = 200000;

    // opcodes the block only skips
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_WEIRD = 4'hF;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_enc;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOKED} t_rx_mode;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_rx_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_kind;
    logic [7:0]          o_data_byte;
    logic [3:0]          o_opcode;
    logic                o_fin;
    logic                o_masked;
    logic [LEN_W-1:0]    o_payload_length;
    logic                o_last;

    int                  fail_count;
    int                  pending;
    longint              cycle_cnt = 0;

    // whole byte stream, built before reset is released
    logic [7:0]          stream_q[$];
    // stream positions where the sender waits for every result to drain
    int                  drain_points[$];

    websocket_frame_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_opcode         (o_opcode),
        .o_fin            (o_fin),
        .o_masked         (o_masked),
        .o_payload_length (o_payload_length),
        .o_last           (o_last)
    );

    websocket_frame_deframer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_kind           (o_kind),
        .i_data_byte      (o_data_byte),
        .i_opcode         (o_opcode),
        .i_fin            (o_fin),
        .i_masked         (o_masked),
        .i_payload_length (o_payload_length),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // frame header: byte 0 carries fin, the reserved bits and the opcode,
    // byte 1 the mask bit and the 7-bit length or its escape code
    task automatic add_header(input logic [3:0] op, input logic fin, input logic [2:0] rsv,
                              input logic masked, input t_len_enc enc, input logic [63:0] len,
                              input logic [31:0] key);
        stream_q.push_back({fin, rsv, op});
        case (enc)
            LEN_SHORT: begin
                stream_q.push_back({masked, len[6:0]});
            end
            LEN_EXT16: begin
                stream_q.push_back({masked, 7'd126});
                stream_q.push_back(len[15:8]);
                stream_q.push_back(len[7:0]);
            end
            default: begin
                stream_q.push_back({masked, 7'd127});
                for (int i = 7; i >= 0; i--) stream_q.push_back(len[8 * i +: 8]);
            end
        endcase
        // key goes out most significant byte first, that byte is key index 0
        if (masked) begin
            for (int i = 3; i >= 0; i--) stream_q.push_back(key[8 * i +: 8]);
        end
    endtask

    // payload bytes, biased toward the all-zero and all-one values
    task automatic add_payload(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) stream_q.push_back(8'h00);
            else if (pick == 1) stream_q.push_back(8'hFF);
            else stream_q.push_back(8'($urandom));
        end
    endtask

    // one random frame: mostly text and binary with short payloads, the rest
    // skipped opcodes, with every length encoding including non-minimal ones
    task automatic add_random_frame();
        logic [3:0] op;
        int         plen;
        int         pick;
        logic       masked;
        op = 4'($urandom_range(0, 15));
        // close would end the stream, so it only appears as the last frame
        if ($urandom_range(0, 5) < 4 || op == OP_CLOSE)
            op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
        pick = $urandom_range(0, 19);
        if (pick < 3) plen = 0;
        else if (pick < 18) plen = $urandom_range(1, 12);
        else plen = $urandom_range(126, 260);
        masked = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 9);
        if (plen < 126 && pick < 6)
            add_header(op, 1'($urandom), 3'($urandom), masked, LEN_SHORT, 64'(plen), $urandom);
        else if (pick < 8)
            add_header(op, 1'($urandom), 3'($urandom), masked, LEN_EXT16, 64'(plen), $urandom);
        else if (pick == 8)
            add_header(op, 1'($urandom), 3'($urandom), masked, LEN_EXT64, 64'(plen), $urandom);
        else
            // reserved top bit of a 64-bit length set, the block drops it
            add_header(op, 1'($urandom), 3'($urandom), masked, LEN_EXT64,
                       {1'b1, 63'(plen)}, $urandom);
        add_payload(plen);
    endtask

    // output side: stretches of always ready, coin-flip ready and mostly stalled
    initial begin
        t_rx_mode mode;
        int       span;
        i_out_ready = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 2));
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:   i_out_ready <= 1'b1;
                    RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                    default:   i_out_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        int burst;
        int gap;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = 8'h00;

        // directed frames
        // text with all reserved bits set, payload extremes, unmasked
        add_header(OP_TEXT, 1'b1, 3'b111, 1'b0, LEN_SHORT, 64'd3, 32'h0);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'h5A);
        // masked binary fragment, key walks through all four key bytes
        add_header(OP_BINARY, 1'b0, 3'b000, 1'b1, LEN_SHORT, 64'd4, 32'hFF00_A53C);
        add_payload(4);
        // empty frames, unmasked and masked: header result with last set
        add_header(OP_TEXT, 1'b1, 3'b000, 1'b0, LEN_SHORT, 64'd0, 32'h0);
        add_header(OP_BINARY, 1'b1, 3'b010, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF);
        // skipped payloads: ping, continuation with non-minimal 16-bit length,
        // unknown opcode with the reserved length bit set
        add_header(OP_PING, 1'b1, 3'b000, 1'b0, LEN_SHORT, 64'd1, 32'h0);
        add_payload(1);
        add_header(OP_CONT, 1'b0, 3'b101, 1'b0, LEN_EXT16, 64'd1, 32'h0);
        add_payload(1);
        add_header(OP_WEIRD, 1'b1, 3'b000, 1'b0, LEN_EXT64, 64'h8000_0000_0000_0001, 32'h0);
        add_payload(1);
        // non-minimal 64-bit length on a text frame
        add_header(OP_TEXT, 1'b1, 3'b000, 1'b0, LEN_EXT64, 64'd2, 32'h0);
        add_payload(2);

        // random frames, with one full drain about halfway
        while (stream_q.size() < STREAM_TARGET) begin
            if (drain_points.size() == 0 && stream_q.size() >= STREAM_TARGET / 2)
                drain_points.push_back(stream_q.size());
            add_random_frame();
        end

        // closing frame with the largest length, then bytes that must be swallowed
        drain_points.push_back(stream_q.size());
        add_header(OP_CLOSE, 1'b1, 3'b000, 1'b1, LEN_EXT64, 64'h7FFF_FFFF_FFFF_FFFF, $urandom);
        add_payload(8);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst = 0;
        for (int n = 0; n < stream_q.size(); n++) begin
            if (drain_points.size() > 0 && drain_points[0] == n) begin
                void'(drain_points.pop_front());
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            if (burst == 0) begin
                // idle gap, then a new burst; long bursts give stretches with no gaps
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            end
            // valid stays high from one byte to the next inside a burst
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_rx_byte  <= stream_q[n];
            do @(posedge i_clk); while (!o_in_ready);
            burst--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
